// ===== rtl/brs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg
// shared types, sizes and codes of the bilinear rgb sampler
// ----------------------------------------------------------------------------
package brs_pkg;

    // frame store and coordinate format
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 512;
    localparam int unsigned FRAC_BITS  = 8;

    // transaction field widths
    localparam int unsigned WCOL_W = 10;
    localparam int unsigned WROW_W = 9;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned SX_W   = 18;
    localparam int unsigned SY_W   = 17;
    localparam int unsigned NUM_CH = 3;

    // store addressing, banked by row and column parity
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned IPX_W      = SX_W - FRAC_BITS;
    localparam int unsigned IPY_W      = SY_W - FRAC_BITS;
    localparam int unsigned NUM_BANKS  = 4;
    localparam int unsigned BANK_SEL_W = 2;
    localparam int unsigned BANK_AW    = (COL_W - 1) + (ROW_W - 1);
    localparam int unsigned BANK_DEPTH = 1 << BANK_AW;

    // blend datapath widths
    localparam int unsigned TOP_W = PIX_W + FRAC_BITS;
    localparam int unsigned V_W   = PIX_W + 2 * FRAC_BITS;

    // configuration port
    localparam int unsigned CFG_IDX_W           = 1;
    localparam int unsigned CFG_DATA_W          = 11;
    localparam int unsigned CANVAS_H_W          = 10;
    localparam int unsigned CANVAS_WIDTH_RESET  = 1024;
    localparam int unsigned CANVAS_HEIGHT_RESET = 512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANVAS_WIDTH  = 1'b0,
        CFG_CANVAS_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } t_func;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_rgb;         // [2] red, [0] blue
    typedef t_rgb [NUM_BANKS-1:0]           t_texels;

    typedef struct packed {
        t_func              func;
        logic [WCOL_W-1:0]  write_col;
        logic [WROW_W-1:0]  write_row;
        logic [PIX_W-1:0]   red_in;
        logic [PIX_W-1:0]   green_in;
        logic [PIX_W-1:0]   blue_in;
        logic [SX_W-1:0]    sample_x;
        logic [SY_W-1:0]    sample_y;
    } t_sampler_in;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
    } t_sampler_out;

    // stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

    // after coordinate clamp
    typedef struct packed {
        t_func                func;
        logic [COL_W-1:0]     x0;
        logic [COL_W-1:0]     x1;
        logic [FRAC_BITS-1:0] ax;
        logic [ROW_W-1:0]     y0;
        logic [ROW_W-1:0]     y1;
        logic [FRAC_BITS-1:0] ay;
        logic                 wr_ok;
        logic [COL_W-1:0]     wr_col;
        logic [ROW_W-1:0]     wr_row;
        t_rgb                 wr_pix;
    } t_s1;

    // travels alongside the bank read data
    typedef struct packed {
        logic                 x0p;
        logic                 x1p;
        logic                 y0p;
        logic                 y1p;
        logic [FRAC_BITS-1:0] ax;
        logic [FRAC_BITS-1:0] ay;
    } t_s2;

endpackage

`default_nettype wire

// ===== rtl/brs_coord.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_coord
// stage 1: splits and clamps the sample coordinate, checks the write address
// ----------------------------------------------------------------------------
module brs_coord import brs_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_en          i_en,
    input  t_sampler_in       i_data,
    input  logic [COL_W-1:0]  i_last_col,
    input  logic [ROW_W-1:0]  i_last_row,
    output t_s1               o_s1
);

    logic [IPX_W-1:0] ipx;
    logic [IPY_W-1:0] ipy;
    logic             clamp_x;
    logic             clamp_y;
    t_s1              n_s1;
    t_s1              r_s1;

    always_comb begin
        ipx     = i_data.sample_x[SX_W-1:FRAC_BITS];
        ipy     = i_data.sample_y[SY_W-1:FRAC_BITS];
        clamp_x = 32'(ipx) >= 32'(i_last_col);
        clamp_y = 32'(ipy) >= 32'(i_last_row);

        n_s1.func = i_data.func;

        // on or past the last column or row: sit on the edge, no fraction
        n_s1.x0 = clamp_x ? i_last_col : COL_W'(ipx);
        n_s1.x1 = clamp_x ? i_last_col : COL_W'(ipx) + COL_W'(1);
        n_s1.ax = clamp_x ? '0 : i_data.sample_x[FRAC_BITS-1:0];
        n_s1.y0 = clamp_y ? i_last_row : ROW_W'(ipy);
        n_s1.y1 = clamp_y ? i_last_row : ROW_W'(ipy) + ROW_W'(1);
        n_s1.ay = clamp_y ? '0 : i_data.sample_y[FRAC_BITS-1:0];

        n_s1.wr_ok  = (32'(i_data.write_col) < 32'(MAX_WIDTH)) &&
                      (32'(i_data.write_row) < 32'(MAX_HEIGHT));
        n_s1.wr_col = COL_W'(i_data.write_col);
        n_s1.wr_row = ROW_W'(i_data.write_row);
        n_s1.wr_pix = {i_data.red_in, i_data.green_in, i_data.blue_in};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

// ===== rtl/brs_frame_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_frame_store
// stage 2: four parity banks, one pixel write or 2x2 fetch per enabled clock
// ----------------------------------------------------------------------------
module brs_frame_store import brs_pkg::*; (
    input  logic     i_clk,
    input  t_pipe_en i_en,
    input  logic     i_s1_valid,
    input  t_s1      i_s1,
    output t_s2      o_s2,
    output t_texels  o_texel
);

    logic                  wr_en;
    logic [BANK_SEL_W-1:0] wr_bank;
    logic [BANK_AW-1:0]    wr_addr;
    t_s2                   n_s2;
    t_s2                   r_s2;

    always_comb begin
        wr_en   = i_en.s2 && i_s1_valid && (i_s1.func == FUNC_WRITE) && i_s1.wr_ok;
        wr_bank = {i_s1.wr_row[0], i_s1.wr_col[0]};
        wr_addr = {i_s1.wr_row[ROW_W-1:1], i_s1.wr_col[COL_W-1:1]};

        n_s2.x0p = i_s1.x0[0];
        n_s2.x1p = i_s1.x1[0];
        n_s2.y0p = i_s1.y0[0];
        n_s2.y1p = i_s1.y1[0];
        n_s2.ax  = i_s1.ax;
        n_s2.ay  = i_s1.ay;
    end

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);

        logic [NUM_CH*PIX_W-1:0] mem [BANK_DEPTH];
        logic [NUM_CH*PIX_W-1:0] r_rd;
        logic [COL_W-1:0]        col_sel;
        logic [ROW_W-1:0]        row_sel;
        logic [BANK_AW-1:0]      rd_addr;

        // each bank serves whichever of the two columns/rows has its parity
        always_comb begin
            col_sel = (i_s1.x0[0] == PX) ? i_s1.x0 : i_s1.x1;
            row_sel = (i_s1.y0[0] == PY) ? i_s1.y0 : i_s1.y1;
            rd_addr = {row_sel[ROW_W-1:1], col_sel[COL_W-1:1]};
        end

        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == BANK_SEL_W'(b))) begin
                mem[wr_addr] <= i_s1.wr_pix;
            end
            if (i_en.s2) begin
                r_rd <= mem[rd_addr];
            end
        end

        assign o_texel[b] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

// ===== rtl/brs_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_blend
// stages 3 to 5: horizontal blend, vertical blend, round half up
// ----------------------------------------------------------------------------
module brs_blend import brs_pkg::*; (
    input  logic         i_clk,
    input  t_pipe_en     i_en,
    input  t_s2          i_s2,
    input  t_texels      i_texel,
    output t_sampler_out o_data
);

    localparam logic [V_W:0] ROUND_HALF =
        {{(V_W + 1 - 2 * FRAC_BITS){1'b0}}, 1'b1, {(2 * FRAC_BITS - 1){1'b0}}};

    // a + (b - a) * f, result has FRAC_BITS fraction bits
    function automatic logic [TOP_W-1:0] lerp_h(
        input logic [PIX_W-1:0]     a,
        input logic [PIX_W-1:0]     b,
        input logic [FRAC_BITS-1:0] f
    );
        logic signed [PIX_W:0]   d;
        logic signed [TOP_W+1:0] p;
        logic signed [TOP_W+1:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        s = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + p;
        return s[TOP_W-1:0];
    endfunction

    // top + (bot - top) * f, result has 2*FRAC_BITS fraction bits
    function automatic logic [V_W-1:0] lerp_v(
        input logic [TOP_W-1:0]     t,
        input logic [TOP_W-1:0]     u,
        input logic [FRAC_BITS-1:0] f
    );
        logic signed [TOP_W:0]   d;
        logic signed [V_W+1:0]   p;
        logic signed [V_W+1:0]   s;
        d = $signed({1'b0, u}) - $signed({1'b0, t});
        p = d * $signed({1'b0, f});
        s = $signed({2'b00, t, {FRAC_BITS{1'b0}}}) + p;
        return s[V_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] round_sat(input logic [V_W-1:0] v);
        logic [V_W:0]   s;
        logic [PIX_W:0] r;
        s = {1'b0, v} + ROUND_HALF;
        r = s[V_W:2*FRAC_BITS];
        return r[PIX_W] ? {PIX_W{1'b1}} : r[PIX_W-1:0];
    endfunction

    logic [NUM_CH-1:0][TOP_W-1:0] n_top;
    logic [NUM_CH-1:0][TOP_W-1:0] n_bot;
    logic [NUM_CH-1:0][TOP_W-1:0] r_top;
    logic [NUM_CH-1:0][TOP_W-1:0] r_bot;
    logic [FRAC_BITS-1:0]         r_ay;
    logic [NUM_CH-1:0][V_W-1:0]   n_v;
    logic [NUM_CH-1:0][V_W-1:0]   r_v;
    t_rgb                         n_out;
    t_rgb                         r_out;
    t_rgb                         p00;
    t_rgb                         p01;
    t_rgb                         p10;
    t_rgb                         p11;

    always_comb begin
        p00 = i_texel[{i_s2.y0p, i_s2.x0p}];
        p01 = i_texel[{i_s2.y0p, i_s2.x1p}];
        p10 = i_texel[{i_s2.y1p, i_s2.x0p}];
        p11 = i_texel[{i_s2.y1p, i_s2.x1p}];
        for (int c = 0; c < NUM_CH; c++) begin
            n_top[c] = lerp_h(p00[c], p01[c], i_s2.ax);
            n_bot[c] = lerp_h(p10[c], p11[c], i_s2.ax);
            n_v[c]   = lerp_v(r_top[c], r_bot[c], r_ay);
            n_out[c] = round_sat(r_v[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_ay  <= i_s2.ay;
        end
        if (i_en.s4) begin
            r_v <= n_v;
        end
        if (i_en.s5) begin
            r_out <= n_out;
        end
    end

    assign o_data = t_sampler_out'(r_out);

endmodule

`default_nettype wire

// ===== rtl/bilinear_rgb_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_rgb_sampler
// rgb frame store with bilinear sampling at fixed-point coordinates
// ----------------------------------------------------------------------------
// The block takes one transaction per clock and returns a sample result, at
// one result per clock while the result side is not stalled; the limit is
// the single texel fetch per clock from the frame store, which is split into
// four banks by row and column parity so that the 2x2 neighbourhood of any
// coordinate comes out of a single read. A write transaction (func = write)
// stores one pixel and returns nothing; a sample transaction returns one rgb
// result. Transactions are handled strictly in order, so a sample sees every
// write taken before it. The frame store is not cleared by reset: sampling a
// pixel that was never written returns unspecified bytes. Program canvas
// width and height only while the pipeline is empty; a size of zero acts as
// one, a size above the store acts as the store size and a height uses only
// its low ten bits. Coordinates past the last column or row sample the edge.
// ----------------------------------------------------------------------------
module bilinear_rgb_sampler import brs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transactions
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_sampler_in           i_data,
    // result transactions
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_sampler_out          o_data,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // effective canvas size minus one, kept in store-index form
    function automatic logic [31:0] last_idx(
        input logic [31:0] v,
        input logic [31:0] vmax
    );
        if (v == 32'd0) begin
            return 32'd0;
        end
        return (v > vmax) ? vmax - 32'd1 : v - 32'd1;
    endfunction

    localparam logic [COL_W-1:0] LAST_COL_RESET =
        COL_W'(last_idx(32'(CANVAS_WIDTH_RESET), 32'(MAX_WIDTH)));
    localparam logic [ROW_W-1:0] LAST_ROW_RESET =
        ROW_W'(last_idx(32'(CANVAS_HEIGHT_RESET), 32'(MAX_HEIGHT)));

    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_last_row;
    logic [4:0]       r_valid;     // one valid bit per stage, [0] is stage 1
    t_pipe_en         en;
    t_s1              s1;
    t_s2              s2;
    t_texels          texel;

    // canvas size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= LAST_COL_RESET;
            r_last_row <= LAST_ROW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CANVAS_WIDTH: begin
                    r_last_col <= COL_W'(last_idx(32'(i_cfg_data), 32'(MAX_WIDTH)));
                end
                CFG_CANVAS_HEIGHT: begin
                    r_last_row <= ROW_W'(last_idx(32'(i_cfg_data[CANVAS_H_W-1:0]),
                                                  32'(MAX_HEIGHT)));
                end
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on; bubbles collapse
    always_comb begin
        en.s5 = !r_valid[4] || i_ready;
        en.s4 = !r_valid[3] || en.s5;
        en.s3 = !r_valid[2] || en.s4;
        en.s2 = !r_valid[1] || en.s3;
        en.s1 = !r_valid[0] || en.s2;
    end

    // writes retire in the store stage, only samples travel further
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en.s1) begin
                r_valid[0] <= i_valid;
            end
            if (en.s2) begin
                r_valid[1] <= r_valid[0] && (s1.func == FUNC_SAMPLE);
            end
            if (en.s3) begin
                r_valid[2] <= r_valid[1];
            end
            if (en.s4) begin
                r_valid[3] <= r_valid[2];
            end
            if (en.s5) begin
                r_valid[4] <= r_valid[3];
            end
        end
    end

    assign o_ready = en.s1;
    assign o_valid = r_valid[4];

    // stage 1: coordinate split and edge clamp
    brs_coord u_coord (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_data     (i_data),
        .i_last_col (r_last_col),
        .i_last_row (r_last_row),
        .o_s1       (s1)
    );

    // stage 2: pixel write or 2x2 texel fetch
    brs_frame_store u_frame_store (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_s1_valid (r_valid[0]),
        .i_s1       (s1),
        .o_s2       (s2),
        .o_texel    (texel)
    );

    // stages 3 to 5: blend and round, stage 5 is the output register
    brs_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_s2    (s2),
        .i_texel (texel),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

// ===== rtl/brs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_checker
// port-level checks of the bilinear rgb sampler
// ----------------------------------------------------------------------------
module brs_checker import brs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input t_sampler_out          o_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result transaction changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // input is taken whenever the output side can move
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || i_ready |-> o_ready)
        else $error("input blocked while output side is free");

    // a pipeline that has taken no input for as long as it is deep cannot invent a result
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !(i_valid && o_ready) ##1 !o_valid && !(i_valid && o_ready)
        ##1 !o_valid && !(i_valid && o_ready) ##1 !o_valid && !(i_valid && o_ready)
        ##1 !o_valid && !(i_valid && o_ready) |=> !o_valid)
        else $error("result without a sample transaction");

endmodule

bind bilinear_rgb_sampler brs_checker u_brs_checker (.*);

`default_nettype wire

// ===== tb/bilinear_rgb_sampler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_rgb_sampler_tb
// loads canvas pixels and samples them at fixed-point coordinates under
// random valid/ready gaps and one or more long output stalls; every result is
// checked against a local bilinear predictor that keeps its own pixel store
// and canvas size, over several canvas sizes including zero and oversize
// ----------------------------------------------------------------------------
module bilinear_rgb_sampler_tb;
    import brs_pkg::*;

    localparam int unsigned PIPE_LATENCY   = 5;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned NUM_PHASES     = 10;
    localparam int unsigned SX_MAX         = (1 << SX_W) - 1;
    localparam int unsigned SY_MAX         = (1 << SY_W) - 1;

    // dut inputs, all known from time zero
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    t_sampler_in           i_data     = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    t_sampler_out          o_data;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // pending input transactions, filled by the stimulus process
    t_sampler_in  pixel_jobs[$];
    // expected sample results, oldest first
    t_sampler_out expected_rgb[$];

    // predictor copy of the frame store and canvas size registers
    logic [23:0]           canvas_model[int unsigned];
    logic [CFG_DATA_W-1:0] canvas_w_cfg = CFG_DATA_W'(CANVAS_WIDTH_RESET);
    logic [CANVAS_H_W-1:0] canvas_h_cfg = CANVAS_H_W'(CANVAS_HEIGHT_RESET);

    // texels the stimulus has already scheduled a write for
    bit canvas_loaded[int unsigned];

    logic        in_taken     = 1'b0;
    logic        calm         = 1'b0;   // no gaps on either side
    bit          held_once    = 1'b0;   // the guaranteed long hold-off is done
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned err_count    = 0;

    bilinear_rgb_sampler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // zero acts as one, oversize acts as the store size
    function automatic int unsigned eff_size(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    // integer part clamped to the last texel, fraction dropped when clamped,
    // neighbour clamped to the edge
    function automatic void split_axis(input int unsigned c, input int unsigned size,
                                       output int unsigned i0, output int unsigned i1,
                                       output int unsigned frac);
        int unsigned ip;
        ip   = c >> FRAC_BITS;
        frac = c & ((1 << FRAC_BITS) - 1);
        if (ip >= size - 1) begin
            ip   = size - 1;
            frac = 0;
        end
        i0 = ip;
        i1 = (ip + 1 < size) ? ip + 1 : ip;
    endfunction

    // applies one accepted transaction: a write updates the store, a sample
    // queues its blended rgb result
    function automatic void predict_sampler(t_sampler_in item);
        int unsigned x0, x1, y0, y1, fx, fy;
        logic [23:0] p00, p01, p10, p11, rgb;
        longint      ax, ay, a, b, d, e, top, bot, v;
        int          sh;
        if (item.func == FUNC_WRITE) begin
            if (item.write_col < MAX_WIDTH && item.write_row < MAX_HEIGHT)
                canvas_model[item.write_row * MAX_WIDTH + item.write_col] =
                    {item.red_in, item.green_in, item.blue_in};
            return;
        end
        split_axis(32'(item.sample_x), eff_size(32'(canvas_w_cfg), MAX_WIDTH), x0, x1, fx);
        split_axis(32'(item.sample_y), eff_size(32'(canvas_h_cfg), MAX_HEIGHT), y0, y1, fy);
        ax  = fx;
        ay  = fy;
        p00 = canvas_model[y0 * MAX_WIDTH + x0];
        p01 = canvas_model[y0 * MAX_WIDTH + x1];
        p10 = canvas_model[y1 * MAX_WIDTH + x0];
        p11 = canvas_model[y1 * MAX_WIDTH + x1];
        for (sh = 0; sh < 24; sh += 8) begin
            a   = p00[sh +: 8];
            b   = p01[sh +: 8];
            d   = p10[sh +: 8];
            e   = p11[sh +: 8];
            // horizontal then vertical blend, exact in 2*FRAC_BITS fraction bits
            top = a * (1 << FRAC_BITS) + (b - a) * ax;
            bot = d * (1 << FRAC_BITS) + (e - d) * ax;
            v   = top * (1 << FRAC_BITS) + (bot - top) * ay;
            v   = (v + (1 << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
            if (v > 255) v = 255;
            rgb[sh +: 8] = v[7:0];
        end
        expected_rgb = {expected_rgb, t_sampler_out'(rgb)};
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_pixel();
        return {rand_byte(), rand_byte(), rand_byte()};
    endfunction

    // sample fields carry junk on a write
    function automatic void queue_write(int unsigned col, int unsigned row, logic [23:0] rgb);
        t_sampler_in item;
        item.func      = FUNC_WRITE;
        item.write_col = WCOL_W'(col);
        item.write_row = WROW_W'(row);
        item.red_in    = rgb[23:16];
        item.green_in  = rgb[15:8];
        item.blue_in   = rgb[7:0];
        item.sample_x  = SX_W'($urandom);
        item.sample_y  = SY_W'($urandom);
        pixel_jobs = {pixel_jobs, item};
        canvas_loaded[row * MAX_WIDTH + col] = 1'b1;
    endfunction

    function automatic void load_if_missing(int unsigned col, int unsigned row);
        if (!canvas_loaded.exists(row * MAX_WIDTH + col))
            queue_write(col, row, rand_pixel());
    endfunction

    // the four texels of the neighbourhood are written first if needed, so no
    // sample ever reads a store entry that was never written
    function automatic void queue_sample(int unsigned sx, int unsigned sy);
        t_sampler_in item;
        int unsigned x0, x1, y0, y1, fx, fy;
        split_axis(sx, eff_size(32'(canvas_w_cfg), MAX_WIDTH), x0, x1, fx);
        split_axis(sy, eff_size(32'(canvas_h_cfg), MAX_HEIGHT), y0, y1, fy);
        load_if_missing(x0, y0);
        load_if_missing(x1, y0);
        load_if_missing(x0, y1);
        load_if_missing(x1, y1);
        item.func      = FUNC_SAMPLE;
        item.write_col = WCOL_W'($urandom);
        item.write_row = WROW_W'($urandom);
        item.red_in    = 8'($urandom);
        item.green_in  = 8'($urandom);
        item.blue_in   = 8'($urandom);
        item.sample_x  = SX_W'(sx);
        item.sample_y  = SY_W'(sy);
        pixel_jobs = {pixel_jobs, item};
    endfunction

    // coordinate on one axis: inside, on the edge, past the edge, integer,
    // half texel, near a hot spot, or anywhere in the field
    function automatic int unsigned pick_coord(int unsigned size, int unsigned hot,
                                               int unsigned maxval);
        int unsigned pos;
        int unsigned frac;
        frac = $urandom_range(0, (1 << FRAC_BITS) - 1);
        case ($urandom_range(0, 9))
            0:    return $urandom_range(0, maxval);
            1:    return ((size - 1) << FRAC_BITS) | frac;
            2:    return (((size > 1) ? size - 2 : 0) << FRAC_BITS) | frac;
            3:    return $urandom_range(0, size - 1) << FRAC_BITS;
            4:    return ($urandom_range(0, size - 1) << FRAC_BITS) | (1 << (FRAC_BITS - 1));
            5, 6: begin
                pos = hot + $urandom_range(0, 7);
                if (pos > size - 1) pos = size - 1;
                return (pos << FRAC_BITS) | frac;
            end
            default: return $urandom_range(0, (size << FRAC_BITS) - 1);
        endcase
    endfunction

    // mostly samples with their texels loaded on demand, some stray writes
    function automatic void fill_random(int unsigned budget);
        int unsigned w, h, hot_x, hot_y, start;
        w     = eff_size(32'(canvas_w_cfg), MAX_WIDTH);
        h     = eff_size(32'(canvas_h_cfg), MAX_HEIGHT);
        hot_x = $urandom_range(0, w - 1);
        hot_y = $urandom_range(0, h - 1);
        start = pixel_jobs.size();
        while (pixel_jobs.size() - start < budget) begin
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 1))
                    queue_write($urandom_range(0, MAX_WIDTH - 1),
                                $urandom_range(0, MAX_HEIGHT - 1), rand_pixel());
                else
                    queue_write($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                                rand_pixel());
            end else begin
                queue_sample(pick_coord(w, hot_x, SX_MAX), pick_coord(h, hot_y, SY_MAX));
            end
        end
    endfunction

    // canvas size writes, only with the pipeline empty
    task automatic set_canvas(int unsigned w_raw, int unsigned h_raw);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CANVAS_WIDTH;
        i_cfg_data <= CFG_DATA_W'(w_raw);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_CANVAS_HEIGHT;
        i_cfg_data <= CFG_DATA_W'(h_raw);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        canvas_w_cfg = CFG_DATA_W'(w_raw);
        canvas_h_cfg = CANVAS_H_W'(h_raw);
    endtask

    // all transactions sent, all results back, then room for trailing writes
    task automatic wait_drained();
        while (pixel_jobs.size() != 0 || i_valid || expected_rgb.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: input transactions, changed at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pixel_jobs.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
                i_valid <= 1'b1;
                i_data  <= pixel_jobs.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random ready gaps plus long hold-offs that back the pipeline
    // up into the input while the driver keeps offering
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!calm && ((!held_once && cycle_count >= 400 && pixel_jobs.size() > 40) ||
                               $urandom_range(0, 699) == 0)) begin
            i_ready   <= 1'b0;
            hold_left <= $urandom_range(40, 100);
            held_once <= 1'b1;
        end else begin
            i_ready   <= calm || $urandom_range(0, 99) >= 14;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: prediction on input transactions, checks on result
    // transactions, watchdog on cycles with no transaction at all
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sampler_out want;
        cycle_count <= cycle_count + 1;
        in_taken    <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready)
            predict_sampler(i_data);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rgb.size() == 0) begin
                err_count <= err_count + 1;
                if (err_count < 10)
                    $display("result r %0d g %0d b %0d with no sample pending",
                             o_data.red_out, o_data.green_out, o_data.blue_out);
            end else begin
                want = expected_rgb.pop_front();
                if (o_data.red_out !== want.red_out || o_data.green_out !== want.green_out ||
                    o_data.blue_out !== want.blue_out) begin
                    err_count <= err_count + 1;
                    if (err_count < 10)
                        $display("sample mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                                 want.red_out, want.green_out, want.blue_out,
                                 o_data.red_out, o_data.green_out, o_data.blue_out);
                end
            end
        end
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready))) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus: reset, directed items at the reset canvas size, then random
    // phases over a range of canvas sizes
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase, w_raw, h_raw, budget;
        bit          no_gaps;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opposite corners of a 2x2 block: exact half-up rounding in the middle
        queue_write(0, 0, 24'hffffff);
        queue_write(1, 0, 24'h000000);
        queue_write(0, 1, 24'h000000);
        queue_write(1, 1, 24'hffffff);
        queue_sample(1 << (FRAC_BITS - 1), 1 << (FRAC_BITS - 1));
        queue_sample(0, 0);
        queue_sample((1 << FRAC_BITS) - 1, 0);
        // far corner of the store with all address bits set
        queue_write(MAX_WIDTH - 1, MAX_HEIGHT - 1, 24'h123456);
        queue_write(MAX_WIDTH - 2, MAX_HEIGHT - 1, 24'hff0080);
        queue_write(MAX_WIDTH - 1, MAX_HEIGHT - 2, 24'h00ff7f);
        queue_write(MAX_WIDTH - 2, MAX_HEIGHT - 2, 24'h808080);
        // largest coordinates land on both edges
        queue_sample(SX_MAX, SY_MAX);
        // last blending position before the edge
        queue_sample(((MAX_WIDTH - 2) << FRAC_BITS) | ((1 << FRAC_BITS) - 1),
                     ((MAX_HEIGHT - 2) << FRAC_BITS) | ((1 << FRAC_BITS) - 1));
        // on the last column the fraction still matters vertically only
        queue_sample(((MAX_WIDTH - 1) << FRAC_BITS) | 'h40, (100 << FRAC_BITS) | 'hc0);
        // on the last row, horizontal blend only
        queue_sample(1 << (FRAC_BITS - 1), ((MAX_HEIGHT - 1) << FRAC_BITS) | 'h80);
        wait_drained();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            no_gaps = 1'b0;
            case (phase)
                0: begin w_raw = 0;    h_raw = 0;    budget = 100; end   // acts as 1x1
                1: begin w_raw = 1;    h_raw = 1;    budget = 60;  end
                2: begin w_raw = 2;    h_raw = 2;    budget = 120; end
                3: begin w_raw = 2047; h_raw = 1023; budget = 200; end   // oversize
                4: begin w_raw = 5;    h_raw = 3;    budget = 150; no_gaps = 1'b1; end
                5: begin w_raw = 1;    h_raw = 512;  budget = 120; end
                6: begin w_raw = 1024; h_raw = 1;    budget = 120; end
                7: begin w_raw = 1024; h_raw = 512;  budget = 200; end
                8: begin
                    w_raw  = $urandom_range(1, MAX_WIDTH);
                    h_raw  = $urandom_range(1, MAX_HEIGHT);
                    budget = 190;
                end
                default: begin
                    w_raw  = $urandom_range(2, 40);
                    h_raw  = $urandom_range(2, 20);
                    budget = 190;
                end
            endcase
            set_canvas(w_raw, h_raw);
            calm <= no_gaps;
            @(posedge i_clk);
            fill_random(budget);
            wait_drained();
        end

        if (err_count == 0 && expected_rgb.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/brs_pkg.sv
rtl/brs_coord.sv
rtl/brs_frame_store.sv
rtl/brs_blend.sv
rtl/bilinear_rgb_sampler.sv
rtl/brs_checker.sv
tb/bilinear_rgb_sampler_tb.sv
